// ----- hdl/ntg_pkg.sv -----
package ntg_pkg;

    localparam int EXPONENT_BITS = 8;
    localparam int RES_W         = 15;
    localparam int OPND_W        = 16;
    localparam int PROD_W        = 2 * OPND_W;
    localparam int MAG_W         = 31;
    localparam int WORD_W        = 64;
    localparam int CFG_IDX_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ROOT_BASE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_R2_FACTOR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_INV    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MOD_INV    = 3'd4;

    localparam logic [RES_W-1:0]  RST_ROOT_BASE = 15'd17;
    localparam logic [RES_W-1:0]  RST_MODULUS   = 15'd3329;
    localparam logic [RES_W-1:0]  RST_R2_FACTOR = 15'd341;
    localparam logic [RES_W-1:0]  RST_LEN_INV   = 15'd3303;
    localparam logic [WORD_W-1:0] RST_MOD_INV   = 64'h3c0f12886ba8f301;

    // which modular product the shared unit is working on
    typedef enum logic [2:0] {
        OP_ACC,   // acc * base
        OP_SQR,   // base * base
        OP_R2,    // acc * r2
        OP_F,     // length_inverse * r2
        OP_ACCF   // acc * f
    } t_op;

endpackage

// ----- hdl/ntt_twiddle_word_generator.sv -----
// Each modular product is a multiply, a 31-step restoring remainder and a
// correction; an exponent with k significant bits needs up to 2k+1 products
// (+2 with scaling), then a 15-step 64-bit shift-add and an output load.
// Throughput: one request at a time; the next is taken once the result is loaded.
// Reset (synchronous, active low) restores the register defaults and idles the sequencer.
module ntt_twiddle_word_generator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [ntg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ntg_pkg::WORD_W-1:0]         i_cfg_data,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [7:0]                         i_s_tdata,  // [7:0] exponent
    input  logic                               i_s_tuser,  // [0] scale_by_inverse_n
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [79:0]                        o_m_tdata   // [63:0] twiddle_word,
                                                           // [78:64] centered_value
);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_CORR, S_FIN, S_OUT} t_state;

    t_state                              r_state;
    ntg_pkg::t_op                        r_op;
    logic [ntg_pkg::RES_W-1:0]           r_root, r_mod, r_r2, r_li;
    logic [ntg_pkg::WORD_W-1:0]          r_minv;
    logic [ntg_pkg::EXPONENT_BITS-1:0]   r_e;
    logic                                r_scale;
    logic signed [ntg_pkg::OPND_W-1:0]   r_acc, r_base, r_f;
    logic [ntg_pkg::MAG_W-1:0]           r_dvd;
    logic [ntg_pkg::OPND_W-1:0]          r_rem;
    logic                                r_neg;
    logic [4:0]                          r_cnt;
    logic [ntg_pkg::WORD_W-1:0]          r_fin;
    logic                                r_ovalid;
    logic [79:0]                         r_odata;

    logic signed [ntg_pkg::OPND_W-1:0]   n_a, n_b;
    logic signed [ntg_pkg::PROD_W-1:0]   n_prod;
    logic [ntg_pkg::PROD_W-1:0]          n_mag;
    logic [ntg_pkg::OPND_W-1:0]          n_w, n_rem;
    logic signed [17:0]                  n_t0, n_t1, n_t2, n_m, n_half;
    logic signed [ntg_pkg::OPND_W-1:0]   n_res;
    logic [ntg_pkg::EXPONENT_BITS-1:0]   n_e_sh;
    logic [ntg_pkg::WORD_W-1:0]          n_addend;

    always_comb begin
        unique case (r_op)
            ntg_pkg::OP_ACC:  begin n_a = r_acc; n_b = r_base; end
            ntg_pkg::OP_SQR:  begin n_a = r_base; n_b = r_base; end
            ntg_pkg::OP_R2:   begin n_a = r_acc; n_b = {r_r2[14], r_r2}; end
            ntg_pkg::OP_F:    begin n_a = {1'b0, r_li}; n_b = {r_r2[14], r_r2}; end
            ntg_pkg::OP_ACCF: begin n_a = r_acc; n_b = r_f; end
            default:          begin n_a = r_acc; n_b = r_base; end
        endcase
        n_prod = n_a * n_b;
        n_mag  = n_prod[ntg_pkg::PROD_W-1] ? 32'(-n_prod) : 32'(n_prod);

        // one restoring remainder step
        n_w   = {r_rem[14:0], r_dvd[ntg_pkg::MAG_W-1]};
        n_rem = (n_w >= {1'b0, r_mod}) ? n_w - {1'b0, r_mod} : n_w;

        // truncating remainder takes the dividend's sign, then center it
        n_m    = $signed({3'b0, r_mod});
        n_half = $signed({4'b0, r_mod[14:1]});
        n_t0   = r_neg ? -$signed({2'b0, r_rem}) : $signed({2'b0, r_rem});
        n_t1   = (n_t0 >= n_half) ? n_t0 - n_m : n_t0;
        n_t2   = (n_t1 < -n_half) ? n_t1 + n_m : n_t1;
        n_res  = (r_mod == '0) ? '0 : n_t2[ntg_pkg::OPND_W-1:0];

        n_e_sh = r_e >> 1;
        n_addend = r_minv << r_cnt[3:0];
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= ntg_pkg::OP_ACC;
            r_ovalid <= 1'b0;
            r_root   <= ntg_pkg::RST_ROOT_BASE;
            r_mod    <= ntg_pkg::RST_MODULUS;
            r_r2     <= ntg_pkg::RST_R2_FACTOR;
            r_li     <= ntg_pkg::RST_LEN_INV;
            r_minv   <= ntg_pkg::RST_MOD_INV;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_idx)
                    ntg_pkg::REG_ROOT_BASE: r_root <= i_cfg_data[14:0];
                    ntg_pkg::REG_MODULUS:   r_mod  <= i_cfg_data[14:0];
                    ntg_pkg::REG_R2_FACTOR: r_r2   <= i_cfg_data[14:0];
                    ntg_pkg::REG_LEN_INV:   r_li   <= i_cfg_data[14:0];
                    ntg_pkg::REG_MOD_INV:   r_minv <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ovalid && i_m_tready && r_state != S_OUT) r_ovalid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_e     <= i_s_tdata[ntg_pkg::EXPONENT_BITS-1:0];
                        r_scale <= i_s_tuser;
                        r_acc   <= 16'sd1;
                        r_base  <= $signed({1'b0, r_root});
                        if (i_s_tdata[ntg_pkg::EXPONENT_BITS-1:0] == '0)
                            r_op <= ntg_pkg::OP_R2;
                        else if (i_s_tdata[0])
                            r_op <= ntg_pkg::OP_ACC;
                        else
                            r_op <= ntg_pkg::OP_SQR;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_dvd   <= n_mag[ntg_pkg::MAG_W-1:0];
                    r_neg   <= n_prod[ntg_pkg::PROD_W-1];
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_dvd <= r_dvd << 1;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(ntg_pkg::MAG_W - 1)) r_state <= S_CORR;
                end
                S_CORR: begin
                    r_state <= S_MUL;
                    unique case (r_op)
                        ntg_pkg::OP_ACC: begin
                            r_acc <= n_res;
                            r_op  <= ntg_pkg::OP_SQR;
                        end
                        ntg_pkg::OP_SQR: begin
                            r_base <= n_res;
                            r_e    <= n_e_sh;
                            if (n_e_sh == '0)  r_op <= ntg_pkg::OP_R2;
                            else if (n_e_sh[0]) r_op <= ntg_pkg::OP_ACC;
                            else               r_op <= ntg_pkg::OP_SQR;
                        end
                        ntg_pkg::OP_R2: begin
                            r_acc <= n_res;
                            if (r_scale) begin
                                r_op <= ntg_pkg::OP_F;
                            end else begin
                                r_fin   <= '0;
                                r_cnt   <= '0;
                                r_state <= S_FIN;
                            end
                        end
                        ntg_pkg::OP_F: begin
                            r_f  <= n_res;
                            r_op <= ntg_pkg::OP_ACCF;
                        end
                        default: begin
                            r_acc   <= n_res;
                            r_fin   <= '0;
                            r_cnt   <= '0;
                            r_state <= S_FIN;
                        end
                    endcase
                end
                S_FIN: begin
                    // top bit of the 15-bit residue carries negative weight
                    if (r_acc[r_cnt[3:0]]) begin
                        if (r_cnt == 5'(ntg_pkg::RES_W - 1)) r_fin <= r_fin - n_addend;
                        else                                  r_fin <= r_fin + n_addend;
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(ntg_pkg::RES_W - 1)) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_odata  <= {1'b0, r_acc[ntg_pkg::RES_W-1:0], r_fin};
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
